FILE: rtl/bbo_pkg.sv
// Bounding box border overlay: shared types, opcodes and field widths.
// No dependencies; used by every module of the block.
package bbo_pkg;

    localparam int OPC_W   = 2;
    localparam int SLOT_W  = 3;
    localparam int FRAC_W  = 16;
    localparam int PIX_W   = 11;
    localparam int LUMA_W  = 8;
    // Edge coordinates hold frame sizes up to 4096 and unclamped right/bottom
    localparam int COORD_W = 13;
    localparam int SCALE_SHIFT = FRAC_W + 1;

    localparam logic [LUMA_W-1:0] LUMA_MAX = 8'd255;

    typedef enum logic [OPC_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_PIXEL = 2'd2
    } opcode_t;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } edge_set_t;

    // Update issued to the box table when an item leaves the input register
    typedef struct packed {
        logic              clr;
        logic              load;
        logic [SLOT_W-1:0] slot;
        edge_set_t         edges;
    } table_wr_t;

endpackage

FILE: rtl/bounding_box_border_overlay.sv
// Top level of the bounding box border overlay: input register, box table,
// per-box border compares and result register. Depends on bbo_pkg and all bbo_ modules.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+----------------------------------------------
//  in      | in_valid, in_stall | opcode, box_slot, center_x/y, box_w/h,
//          |                    | pixel_col, pixel_row, luma_in
//  out     | out_valid,out_stall| luma_out, on_border
//
// One item per clock sustained unless a stalled result holds back a pixel.
// Latency is the input register plus the result register; the edge multiplies and
// the parallel box compares sit between them.
// Reset clears all box valid bits and both stage valids; stored edges are not reset.
// A stalled result holds the pixel stage, which then stalls the input; box loads
// and clears still drain while a result waits.
module bounding_box_border_overlay #(
    parameter int FRAME_WIDTH    = 1920,
    parameter int FRAME_HEIGHT   = 1080,
    parameter int MAX_BOXES      = 8,
    parameter int HALF_THICKNESS = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bbo_pkg::OPC_W-1:0]    opcode,
    input  logic [bbo_pkg::SLOT_W-1:0]   box_slot,
    input  logic [bbo_pkg::FRAC_W-1:0]   center_x,
    input  logic [bbo_pkg::FRAC_W-1:0]   center_y,
    input  logic [bbo_pkg::FRAC_W-1:0]   box_w,
    input  logic [bbo_pkg::FRAC_W-1:0]   box_h,
    input  logic [bbo_pkg::PIX_W-1:0]    pixel_col,
    input  logic [bbo_pkg::PIX_W-1:0]    pixel_row,
    input  logic [bbo_pkg::LUMA_W-1:0]   luma_in,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bbo_pkg::LUMA_W-1:0]   luma_out,
    output logic                         on_border
);

    localparam int CW = bbo_pkg::COORD_W;

    // Input register
    logic                         s1_valid_reg, s1_valid_next;
    logic [bbo_pkg::OPC_W-1:0]    op_reg;
    logic [bbo_pkg::SLOT_W-1:0]   slot_reg;
    logic [bbo_pkg::FRAC_W-1:0]   cx_reg, cy_reg, bw_reg, bh_reg;
    logic [bbo_pkg::PIX_W-1:0]    col_reg, row_reg;
    logic [bbo_pkg::LUMA_W-1:0]   luma_reg;

    // Result register
    logic                         out_valid_reg, out_valid_next;
    logic [bbo_pkg::LUMA_W-1:0]   luma_out_reg;
    logic                         on_border_reg;

    logic                         accept, s1_fire, is_pixel;
    bbo_pkg::edge_set_t           new_edges;
    bbo_pkg::table_wr_t           tbl_wr;
    logic [MAX_BOXES-1:0]         box_valid;
    bbo_pkg::edge_set_t [MAX_BOXES-1:0] box_edges;
    logic [MAX_BOXES-1:0]         hit_vec;
    logic [CW-1:0]                col_ext, row_ext;
    logic                         in_frame, hit;

    assign is_pixel = (op_reg == bbo_pkg::OP_PIXEL);
    assign s1_fire  = s1_valid_reg && (!is_pixel || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            slot_reg <= box_slot;
            cx_reg   <= center_x;
            cy_reg   <= center_y;
            bw_reg   <= box_w;
            bh_reg   <= box_h;
            col_reg  <= pixel_col;
            row_reg  <= pixel_row;
            luma_reg <= luma_in;
        end
    end

    bbo_edge_calc #(
        .FRAME_WIDTH    (FRAME_WIDTH),
        .FRAME_HEIGHT   (FRAME_HEIGHT),
        .HALF_THICKNESS (HALF_THICKNESS)
    ) u_edge_calc (
        .center_x (cx_reg),
        .center_y (cy_reg),
        .box_w    (bw_reg),
        .box_h    (bh_reg),
        .edges    (new_edges)
    );

    // Table updates land at the same edge the next item enters, so it sees them
    always_comb
    begin
        tbl_wr.clr   = s1_fire && (op_reg == bbo_pkg::OP_CLEAR);
        tbl_wr.load  = s1_fire && (op_reg == bbo_pkg::OP_LOAD);
        tbl_wr.slot  = slot_reg;
        tbl_wr.edges = new_edges;
    end

    bbo_box_table #(
        .MAX_BOXES (MAX_BOXES)
    ) u_box_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (tbl_wr),
        .box_valid (box_valid),
        .box_edges (box_edges)
    );

    assign col_ext = CW'(col_reg);
    assign row_ext = CW'(row_reg);

    for (genvar i = 0; i < MAX_BOXES; i++)
    begin : g_box
        bbo_border_hit #(
            .HALF_THICKNESS (HALF_THICKNESS)
        ) u_border_hit (
            .box_valid (box_valid[i]),
            .box_edges (box_edges[i]),
            .col       (col_ext),
            .row       (row_ext),
            .hit       (hit_vec[i])
        );
    end

    // Off-frame pixels never take a border
    assign in_frame = (col_ext < CW'(FRAME_WIDTH)) && (row_ext < CW'(FRAME_HEIGHT));
    assign hit      = in_frame && (|hit_vec);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && is_pixel)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && is_pixel)
        begin
            luma_out_reg  <= hit ? bbo_pkg::LUMA_MAX : luma_reg;
            on_border_reg <= hit;
        end
    end

    assign out_valid = out_valid_reg;
    assign luma_out  = luma_out_reg;
    assign on_border = on_border_reg;

endmodule

FILE: rtl/bbo_edge_calc.sv
// Converts a box centre and size (Q0.16 fractions) into clamped pixel edges.
// Depends on bbo_pkg.
module bbo_edge_calc #(
    parameter int FRAME_WIDTH    = 1920,
    parameter int FRAME_HEIGHT   = 1080,
    parameter int HALF_THICKNESS = 2
) (
    input  logic [bbo_pkg::FRAC_W-1:0] center_x,
    input  logic [bbo_pkg::FRAC_W-1:0] center_y,
    input  logic [bbo_pkg::FRAC_W-1:0] box_w,
    input  logic [bbo_pkg::FRAC_W-1:0] box_h,
    output bbo_pkg::edge_set_t         edges
);

    localparam int SUM_W  = bbo_pkg::FRAC_W + 2;
    localparam int PROD_W = SUM_W + bbo_pkg::COORD_W;
    localparam int Q_W    = PROD_W - bbo_pkg::SCALE_SHIFT;
    localparam int CW     = bbo_pkg::COORD_W;

    localparam logic [Q_W-1:0] THICK = Q_W'(HALF_THICKNESS);
    localparam logic [Q_W-1:0] X_MAX = Q_W'(FRAME_WIDTH - HALF_THICKNESS);
    localparam logic [Q_W-1:0] Y_MAX = Q_W'(FRAME_HEIGHT - HALF_THICKNESS);

    // floor(sum * span / 2^17)
    function automatic logic [Q_W-1:0] scale(input logic [SUM_W-1:0] sum,
                                             input logic [CW-1:0] span);
        logic [PROD_W-1:0] prod;
        begin
            prod = PROD_W'(sum) * PROD_W'(span);
            scale = prod[PROD_W-1:bbo_pkg::SCALE_SHIFT];
        end
    endfunction

    logic [SUM_W-1:0] twice_x, twice_y;
    logic [SUM_W-1:0] lo_x, lo_y, hi_x, hi_y;
    logic             neg_x, neg_y;
    logic [Q_W-1:0]   left_q, top_q, right_q, bottom_q;

    always_comb
    begin
        twice_x = {1'b0, center_x, 1'b0};
        twice_y = {1'b0, center_y, 1'b0};
        neg_x   = twice_x < SUM_W'(box_w);
        neg_y   = twice_y < SUM_W'(box_h);
        lo_x    = twice_x - SUM_W'(box_w);
        lo_y    = twice_y - SUM_W'(box_h);
        hi_x    = twice_x + SUM_W'(box_w);
        hi_y    = twice_y + SUM_W'(box_h);

        left_q   = scale(lo_x, CW'(FRAME_WIDTH));
        top_q    = scale(lo_y, CW'(FRAME_HEIGHT));
        right_q  = scale(hi_x, CW'(FRAME_WIDTH));
        bottom_q = scale(hi_y, CW'(FRAME_HEIGHT));

        // A negative start clamps to the border half-width as well
        if (neg_x || left_q < THICK)
            left_q = THICK;
        if (neg_y || top_q < THICK)
            top_q = THICK;
        if (right_q > X_MAX)
            right_q = X_MAX;
        if (bottom_q > Y_MAX)
            bottom_q = Y_MAX;

        edges.left   = left_q[CW-1:0];
        edges.top    = top_q[CW-1:0];
        edges.right  = right_q[CW-1:0];
        edges.bottom = bottom_q[CW-1:0];
    end

endmodule

FILE: rtl/bbo_box_table.sv
// Box table: edge registers per slot with a valid bit each.
// Depends on bbo_pkg.
module bbo_box_table #(
    parameter int MAX_BOXES = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bbo_pkg::table_wr_t                   wr,
    output logic [MAX_BOXES-1:0]                 box_valid,
    output bbo_pkg::edge_set_t [MAX_BOXES-1:0]   box_edges
);

    logic [MAX_BOXES-1:0]               valid_reg, valid_next;
    bbo_pkg::edge_set_t [MAX_BOXES-1:0] edges_reg, edges_next;

    always_comb
    begin
        valid_next = valid_reg;
        edges_next = edges_reg;
        for (int i = 0; i < MAX_BOXES; i++)
        begin
            if (wr.clr)
                valid_next[i] = 1'b0;
            // Slots beyond the table never match and are dropped
            if (wr.load && int'(wr.slot) == i)
            begin
                valid_next[i] = 1'b1;
                edges_next[i] = wr.edges;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        edges_reg <= edges_next;
    end

    assign box_valid = valid_reg;
    assign box_edges = edges_reg;

endmodule

FILE: rtl/bbo_border_hit.sv
// Tests one pixel position against the border band of one stored box.
// Depends on bbo_pkg.
module bbo_border_hit #(
    parameter int HALF_THICKNESS = 2
) (
    input  logic                         box_valid,
    input  bbo_pkg::edge_set_t           box_edges,
    input  logic [bbo_pkg::COORD_W-1:0]  col,
    input  logic [bbo_pkg::COORD_W-1:0]  row,
    output logic                         hit
);

    localparam int HW = bbo_pkg::COORD_W + 1;
    localparam logic [HW-1:0] THICK = HW'(HALF_THICKNESS);

    // |a - e| <= T without signed arithmetic
    function automatic logic near(input logic [HW-1:0] a, input logic [HW-1:0] e);
        begin
            near = (a + THICK >= e) && (a <= e + THICK);
        end
    endfunction

    logic [HW-1:0] c, r, l, t, rt, b;
    logic          h_span, v_span, h_band, v_band;

    always_comb
    begin
        c  = HW'(col);
        r  = HW'(row);
        l  = HW'(box_edges.left);
        t  = HW'(box_edges.top);
        rt = HW'(box_edges.right);
        b  = HW'(box_edges.bottom);

        h_span = (c + THICK >= l) && (c < rt + THICK);
        v_span = (r >= t) && (r < b);
        h_band = h_span && (near(r, t) || near(r, b));
        v_band = v_span && (near(c, l) || near(c, rt));
        hit    = box_valid && (h_band || v_band);
    end

endmodule
